### rtl/core/swerve_inverse_kinematics_macros.svh
// ---------------------------------------------------------------------------
// Swerve inverse kinematics assertion macros
// Shared concurrent assertion forms, clocked on i_clk, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef SWERVE_INVERSE_KINEMATICS_MACROS_SVH
`define SWERVE_INVERSE_KINEMATICS_MACROS_SVH

// Same-cycle implication
`define SIK_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SIK_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/sik_pkg.sv
// ---------------------------------------------------------------------------
// Swerve inverse kinematics package
// Widths, register indexes, fixed-point constants and the CORDIC angle table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sik_pkg;

    // Geometry and iteration counts
    localparam int NUM_WHEELS    = 4;
    localparam int CORDIC_STEPS  = 16;
    localparam int STEPS_PER_STG = 2;
    localparam int CORDIC_STAGES = (CORDIC_STEPS + STEPS_PER_STG - 1) / STEPS_PER_STG;

    // Datapath widths
    localparam int VEL_W  = 16;
    localparam int DIM_W  = 12;
    localparam int RCP_W  = 21;
    localparam int PRD_W  = VEL_W + DIM_W + 1;   // yaw rate times signed offset
    localparam int WV_W   = 18;                  // wheel velocity, signed
    localparam int GUARD  = 8;
    localparam int CW     = 29;                  // CORDIC x/y, signed
    localparam int ZW     = 20;                  // CORDIC angle, signed Q.16
    localparam int MAG_W  = CW - 1;
    localparam int GAIN_W = 24;
    localparam int ANG_W  = 15;
    localparam int SPD_W  = 24;

    // Configuration register indexes
    localparam logic [1:0] CFG_HALF_WHEEL_BASE = 2'd0;
    localparam logic [1:0] CFG_HALF_TRACK      = 2'd1;
    localparam logic [1:0] CFG_RECIP_RADIUS    = 2'd2;

    // Register reset values
    localparam logic [DIM_W-1:0] RST_HALF_WHEEL_BASE = 12'd350;
    localparam logic [DIM_W-1:0] RST_HALF_TRACK      = 12'd150;
    localparam logic [RCP_W-1:0] RST_RECIP_RADIUS    = 21'd258111;

    // Fixed-point constants
    localparam logic signed [ZW-1:0] ANGLE_HALF_PI = 20'sd102944;
    localparam logic signed [15:0]   ANGLE_PI_Q12  = 16'sd12868;
    localparam logic [GAIN_W-1:0]    INV_GAIN_Q24  = 24'd10188014;
    localparam logic [SPD_W-1:0]     SPEED_MAX     = 24'hFFFFFF;

    // Wheel codes
    localparam logic [1:0] WHEEL_FL = 2'd0;
    localparam logic [1:0] WHEEL_RR = 2'd3;

    // Tag that rides along with each wheel through the pipeline
    typedef struct packed {
        logic       valid;
        logic [1:0] wheel;
        logic       zero;
    } t_tag;

    // atan(2^-i) in Q.16, zero past i = 16
    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:    v = 20'sd51472;
            5'd1:    v = 20'sd30386;
            5'd2:    v = 20'sd16055;
            5'd3:    v = 20'sd8150;
            5'd4:    v = 20'sd4091;
            5'd5:    v = 20'sd2047;
            5'd6:    v = 20'sd1024;
            5'd7:    v = 20'sd512;
            5'd8:    v = 20'sd256;
            5'd9:    v = 20'sd128;
            5'd10:   v = 20'sd64;
            5'd11:   v = 20'sd32;
            5'd12:   v = 20'sd16;
            5'd13:   v = 20'sd8;
            5'd14:   v = 20'sd4;
            5'd15:   v = 20'sd2;
            5'd16:   v = 20'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/swerve_inverse_kinematics.sv
// ---------------------------------------------------------------------------
// Swerve inverse kinematics
// Turns one body twist into steering angle and wheel speed for four wheels.
// ---------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  twist     in         start && !busy            i_vel_x, i_vel_y, i_yaw_rate
//  wheel     out        o_strobe, one cycle       o_wheel_index, o_steer_angle,
//                                                 o_wheel_speed, o_last
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
//  For each twist the sequencer issues one wheel per cycle into a
//  single pipeline (offset multiply, wheel velocity, CORDIC_STAGES CORDIC
//  stages of two iterations each, gain multiply, rounding, radius multiply,
//  output). busy is high while the first three wheels issue; the next twist
//  can be taken as the last wheel issues.
//  Reset clears valid bits and restores register defaults; results cannot be
//  stalled, so the pipeline never holds.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module swerve_inverse_kinematics
    import sik_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [VEL_W-1:0]  i_vel_x,
    input  logic signed [VEL_W-1:0]  i_vel_y,
    input  logic signed [VEL_W-1:0]  i_yaw_rate,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [RCP_W-1:0]         i_cfg_data,
    output logic                     o_strobe,
    output logic [1:0]               o_wheel_index,
    output logic signed [ANG_W-1:0]  o_steer_angle,
    output logic [SPD_W-1:0]         o_wheel_speed,
    output logic                     o_last
);

    // -----------------------------------------------------------------------
    // Configuration registers
    // -----------------------------------------------------------------------
    logic [DIM_W-1:0] r_half_wheel_base;
    logic [DIM_W-1:0] r_half_track;
    logic [RCP_W-1:0] r_recip_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_wheel_base <= RST_HALF_WHEEL_BASE;
            r_half_track      <= RST_HALF_TRACK;
            r_recip_radius    <= RST_RECIP_RADIUS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HALF_WHEEL_BASE: r_half_wheel_base <= i_cfg_data[DIM_W-1:0];
                CFG_HALF_TRACK:      r_half_track      <= i_cfg_data[DIM_W-1:0];
                CFG_RECIP_RADIUS:    r_recip_radius    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Wheel sequencer: hold the twist, issue one wheel per cycle
    // -----------------------------------------------------------------------
    logic                    r_seq_active;
    logic [1:0]              r_seq_wheel;
    logic signed [VEL_W-1:0] r_tw_vx;
    logic signed [VEL_W-1:0] r_tw_vy;
    logic signed [VEL_W-1:0] r_tw_w;
    logic                    accept;

    assign busy   = r_seq_active && (r_seq_wheel != WHEEL_RR);
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_active <= 1'b0;
            r_seq_wheel  <= WHEEL_FL;
        end else if (accept) begin
            r_seq_active <= 1'b1;
            r_seq_wheel  <= WHEEL_FL;
        end else if (r_seq_active) begin
            r_seq_active <= (r_seq_wheel != WHEEL_RR);
            r_seq_wheel  <= r_seq_wheel + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tw_vx <= i_vel_x;
            r_tw_vy <= i_vel_y;
            r_tw_w  <= i_yaw_rate;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 1: yaw rate times wheel offsets
    // -----------------------------------------------------------------------
    logic signed [DIM_W:0]   lx;
    logic signed [DIM_W:0]   ly;
    t_tag                    r_s1_tag;
    logic signed [PRD_W-1:0] r_s1_px;
    logic signed [PRD_W-1:0] r_s1_py;
    logic signed [VEL_W-1:0] r_s1_vx;
    logic signed [VEL_W-1:0] r_s1_vy;

    // Front wheels sit at +half base, left wheels at +half track
    always_comb begin
        lx = r_seq_wheel[1] ? -$signed({1'b0, r_half_wheel_base})
                            :  $signed({1'b0, r_half_wheel_base});
        ly = r_seq_wheel[0] ? -$signed({1'b0, r_half_track})
                            :  $signed({1'b0, r_half_track});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
        end else begin
            r_s1_tag.valid <= r_seq_active;
            r_s1_tag.wheel <= r_seq_wheel;
            r_s1_tag.zero  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_px <= r_tw_w * lx;
        r_s1_py <= r_tw_w * ly;
        r_s1_vx <= r_tw_vx;
        r_s1_vy <= r_tw_vy;
    end

    // -----------------------------------------------------------------------
    // Stage 2: wheel velocity, scale, half-plane pre-rotation
    // -----------------------------------------------------------------------
    logic signed [PRD_W-13:0] sh_x;
    logic signed [PRD_W-13:0] sh_y;
    logic signed [WV_W-1:0]   wvx;
    logic signed [WV_W-1:0]   wvy;
    logic signed [CW-1:0]     sx;
    logic signed [CW-1:0]     sy;
    logic signed [CW-1:0]     n_x0;
    logic signed [CW-1:0]     n_y0;
    logic signed [ZW-1:0]     n_z0;

    t_tag                 r_c_tag [0:CORDIC_STAGES];
    logic signed [CW-1:0] r_cx    [0:CORDIC_STAGES];
    logic signed [CW-1:0] r_cy    [0:CORDIC_STAGES];
    logic signed [ZW-1:0] r_cz    [0:CORDIC_STAGES];

    always_comb begin
        // floor shift by 12 is the upper slice of the product
        sh_y = r_s1_py[PRD_W-1:12];
        sh_x = r_s1_px[PRD_W-1:12];
        wvx  = WV_W'(r_s1_vx) - WV_W'(sh_y);
        wvy  = WV_W'(r_s1_vy) + WV_W'(sh_x);
        sx   = CW'(wvx) <<< GUARD;
        sy   = CW'(wvy) <<< GUARD;
        n_x0 = sx;
        n_y0 = sy;
        n_z0 = '0;
        // Left half plane: turn by -90 or +90 degrees first
        if (wvx < 0) begin
            if (wvy >= 0) begin
                n_x0 = sy;
                n_y0 = -sx;
                n_z0 = ANGLE_HALF_PI;
            end else begin
                n_x0 = -sy;
                n_y0 = sx;
                n_z0 = -ANGLE_HALF_PI;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_tag[0] <= '0;
        end else begin
            r_c_tag[0].valid <= r_s1_tag.valid;
            r_c_tag[0].wheel <= r_s1_tag.wheel;
            r_c_tag[0].zero  <= (wvx == '0) && (wvy == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx[0] <= n_x0;
        r_cy[0] <= n_y0;
        r_cz[0] <= n_z0;
    end

    // -----------------------------------------------------------------------
    // CORDIC vectoring stages, two iterations each
    // -----------------------------------------------------------------------
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        localparam int I0 = STEPS_PER_STG * g;
        localparam int I1 = STEPS_PER_STG * g + 1;

        logic signed [CW-1:0] x1, y1, x2, y2;
        logic signed [ZW-1:0] z1, z2;

        always_comb begin
            // first iteration
            if (r_cy[g] >= 0) begin
                x1 = r_cx[g] + (r_cy[g] >>> I0);
                y1 = r_cy[g] - (r_cx[g] >>> I0);
                z1 = r_cz[g] + atan_q16(5'(I0));
            end else begin
                x1 = r_cx[g] - (r_cy[g] >>> I0);
                y1 = r_cy[g] + (r_cx[g] >>> I0);
                z1 = r_cz[g] - atan_q16(5'(I0));
            end
            // second iteration, skipped past the last step
            x2 = x1;
            y2 = y1;
            z2 = z1;
            if (I1 < CORDIC_STEPS) begin
                if (y1 >= 0) begin
                    x2 = x1 + (y1 >>> I1);
                    y2 = y1 - (x1 >>> I1);
                    z2 = z1 + atan_q16(5'(I1));
                end else begin
                    x2 = x1 - (y1 >>> I1);
                    y2 = y1 + (x1 >>> I1);
                    z2 = z1 - atan_q16(5'(I1));
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_c_tag[g+1] <= '0;
            end else begin
                r_c_tag[g+1] <= r_c_tag[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_cx[g+1] <= x2;
            r_cy[g+1] <= y2;
            r_cz[g+1] <= z2;
        end
    end

    // -----------------------------------------------------------------------
    // Finish 1: round and clamp the angle, multiply x by the inverse gain
    // -----------------------------------------------------------------------
    logic signed [ZW-1:0]        z_rnd;
    logic signed [15:0]          z_q12;
    logic signed [15:0]          n_ang;
    logic [MAG_W-1:0]            x_pos;
    t_tag                        r_f1_tag;
    logic [MAG_W+GAIN_W-1:0]     r_f1_prod;
    logic signed [ANG_W-1:0]     r_f1_ang;

    always_comb begin
        z_rnd = r_cz[CORDIC_STAGES] + ZW'(8);
        z_q12 = z_rnd[ZW-1:4];
        if (z_q12 > ANGLE_PI_Q12) begin
            n_ang = ANGLE_PI_Q12;
        end else if (z_q12 < -ANGLE_PI_Q12) begin
            n_ang = -ANGLE_PI_Q12;
        end else begin
            n_ang = z_q12;
        end
        // zero vector keeps x at zero, so speed follows
        if (r_c_tag[CORDIC_STAGES].zero) begin
            n_ang = '0;
        end
        x_pos = r_cx[CORDIC_STAGES][CW-1] ? '0 : r_cx[CORDIC_STAGES][MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_tag <= '0;
        end else begin
            r_f1_tag <= r_c_tag[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1_prod <= x_pos * INV_GAIN_Q24;
        r_f1_ang  <= n_ang[ANG_W-1:0];
    end

    // -----------------------------------------------------------------------
    // Finish 2: round the magnitude
    // -----------------------------------------------------------------------
    localparam logic [MAG_W+GAIN_W-1:0] RND_24 = (MAG_W + GAIN_W)'(1) << 23;

    logic [MAG_W+GAIN_W-1:0] mag_sum;
    t_tag                    r_f2_tag;
    logic [MAG_W-1:0]        r_f2_mag;
    logic signed [ANG_W-1:0] r_f2_ang;

    assign mag_sum = r_f1_prod + RND_24;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_tag <= '0;
        end else begin
            r_f2_tag <= r_f1_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f2_mag <= mag_sum[MAG_W+GAIN_W-1:24];
        r_f2_ang <= r_f1_ang;
    end

    // -----------------------------------------------------------------------
    // Finish 3: magnitude times reciprocal radius
    // -----------------------------------------------------------------------
    t_tag                    r_f3_tag;
    logic [MAG_W+RCP_W-1:0]  r_f3_prod;
    logic signed [ANG_W-1:0] r_f3_ang;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f3_tag <= '0;
        end else begin
            r_f3_tag <= r_f2_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f3_prod <= r_f2_mag * r_recip_radius;
        r_f3_ang  <= r_f2_ang;
    end

    // -----------------------------------------------------------------------
    // Output: round, saturate, drive the result ports
    // -----------------------------------------------------------------------
    localparam logic [MAG_W+RCP_W-1:0] RND_SPD = (MAG_W + RCP_W)'(1) << 23;

    logic [MAG_W+RCP_W-1:0] spd_sum;
    logic [MAG_W+RCP_W-25:0] spd_full;
    logic [SPD_W-1:0]       n_speed;

    always_comb begin
        spd_sum  = r_f3_prod + RND_SPD;
        spd_full = spd_sum[MAG_W+RCP_W-1:24];
        if (spd_full > (MAG_W + RCP_W - 24)'(SPEED_MAX)) begin
            n_speed = SPEED_MAX;
        end else begin
            n_speed = spd_full[SPD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_f3_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_wheel_index <= r_f3_tag.wheel;
        o_last        <= (r_f3_tag.wheel == WHEEL_RR);
        o_steer_angle <= r_f3_ang;
        o_wheel_speed <= n_speed;
    end

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `include "swerve_inverse_kinematics_macros.svh"

    `SIK_ASSERT_NEXT(a_accept_starts_fl, start && !busy, r_seq_active && (r_seq_wheel == WHEEL_FL), "accepted twist did not start at the front-left wheel")
    `SIK_ASSERT_NEXT(a_busy_keeps_issuing, busy, r_seq_active, "sequencer stopped while busy")
    `SIK_ASSERT_NEXT(a_results_contiguous, o_strobe && !o_last, o_strobe, "wheel results of one twist are not back to back")
    `SIK_ASSERT_NOW(a_zero_speed_zero_angle, r_f1_tag.valid && r_f1_tag.zero, (r_f1_ang == '0) && (r_f1_prod == '0), "zero wheel vector gave a nonzero angle or magnitude")

endmodule

### tb/tb.sv
// ---------------------------------------------------------------------------
// Swerve inverse kinematics testbench
// Sends body twists and checks each wheel result against a fixed-point
// predictor of the offset math, the vectoring CORDIC and the speed scaling.
// Geometry and wheel radius are changed between phases while the block is
// idle. Directed twists, then random twists; idle bursts in all but the last.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import sik_pkg::*;

    // Predictor constants
    localparam int      WHEEL_COUNT   = 4;
    localparam int      CORDIC_ITERS  = 16;
    localparam longint  HALF_PI_Q16   = 102944;
    localparam longint  PI_Q12        = 12868;
    localparam longint  GAIN_COMP_Q24 = 10188014;
    localparam longint  SPEED_CEIL    = 16777215;
    localparam int      SETTLE_CYCLES = 24;
    localparam int      PHASE_ITEMS   = 45;

    // Register index with no register behind it
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [VEL_W-1:0] yaw_rate;
    } twist_t;

    typedef struct packed {
        logic [1:0]              index;
        logic signed [ANG_W-1:0] angle;
        logic [SPD_W-1:0]        speed;
        logic                    is_last;
    } wheel_result_t;

    // -----------------------------------------------------------------------
    // Scoreboard: register copy, wheel predictor, queue of pending wheels
    // -----------------------------------------------------------------------
    class wheel_scoreboard;
        logic [DIM_W-1:0] half_wheel_base;
        logic [DIM_W-1:0] half_track;
        logic [RCP_W-1:0] recip_radius;
        longint           atan_q16[CORDIC_ITERS];
        wheel_result_t    pending_wheels[$];
        int unsigned      failures;

        function new();
            half_wheel_base = 12'd350;
            half_track      = 12'd150;
            recip_radius    = 21'd258111;
            atan_q16 = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                         256, 128, 64, 32, 16, 8, 4, 2};
            failures = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [RCP_W-1:0] data);
            case (idx)
                CFG_HALF_WHEEL_BASE: half_wheel_base = data[DIM_W-1:0];
                CFG_HALF_TRACK:      half_track      = data[DIM_W-1:0];
                CFG_RECIP_RADIUS:    recip_radius    = data;
                default: ;
            endcase
        endfunction

        // Vectoring CORDIC on one wheel velocity, then gain and radius scaling
        function void solve_wheel(longint vx, longint vy,
                                  output logic signed [ANG_W-1:0] angle,
                                  output logic [SPD_W-1:0] speed);
            longint x, y, z, t, dx, dy, mag, sp;
            if (vx == 0 && vy == 0) begin
                angle = '0;
                speed = '0;
                return;
            end
            x = vx * 256;
            y = vy * 256;
            z = 0;
            // Rotate left-half-plane vectors by a quarter turn first
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y;
                    y = -t;
                    z = HALF_PI_Q16;
                end else begin
                    x = -y;
                    y = t;
                    z = -HALF_PI_Q16;
                end
            end
            for (int i = 0; i < CORDIC_ITERS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + atan_q16[i];
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - atan_q16[i];
                end
            end
            z = (z + 8) >>> 4;
            if (z > PI_Q12) z = PI_Q12;
            if (z < -PI_Q12) z = -PI_Q12;
            angle = z[ANG_W-1:0];
            if (x < 0) x = 0;
            mag = (x * GAIN_COMP_Q24 + (64'sd1 <<< 23)) >>> 24;
            sp  = (mag * longint'(recip_radius) + (64'sd1 <<< 23)) >>> 24;
            if (sp > SPEED_CEIL) sp = SPEED_CEIL;
            speed = sp[SPD_W-1:0];
        endfunction

        // Queue the four wheel results of an accepted twist
        function void note_twist(twist_t tw);
            longint bx, by, w, lx, ly, hb, ht;
            wheel_result_t r;
            bx = longint'(tw.vel_x);
            by = longint'(tw.vel_y);
            w  = longint'(tw.yaw_rate);
            hb = longint'(half_wheel_base);
            ht = longint'(half_track);
            for (int k = 0; k < WHEEL_COUNT; k++) begin
                lx = (k < 2) ? hb : -hb;
                ly = (k % 2 == 0) ? ht : -ht;
                r.index   = k[1:0];
                r.is_last = (r.index == WHEEL_RR);
                solve_wheel(bx - ((w * ly) >>> 12), by + ((w * lx) >>> 12),
                            r.angle, r.speed);
                pending_wheels.push_back(r);
            end
        endfunction

        function void check_wheel(wheel_result_t got);
            wheel_result_t exp_r;
            if (pending_wheels.size() == 0) begin
                $error("wheel result with none expected: wheel_index %0d", got.index);
                failures++;
                return;
            end
            exp_r = pending_wheels.pop_front();
            if (got.index !== exp_r.index) begin
                $error("wheel_index: expected %0d, got %0d", exp_r.index, got.index);
                failures++;
            end
            if (got.angle !== exp_r.angle) begin
                $error("steer_angle: expected %0d, got %0d", exp_r.angle, got.angle);
                failures++;
            end
            if (got.speed !== exp_r.speed) begin
                $error("wheel_speed: expected %0d, got %0d", exp_r.speed, got.speed);
                failures++;
            end
            if (got.is_last !== exp_r.is_last) begin
                $error("last: expected %0b, got %0b", exp_r.is_last, got.is_last);
                failures++;
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // Block under test
    // -----------------------------------------------------------------------
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic signed [VEL_W-1:0] i_vel_x = '0;
    logic signed [VEL_W-1:0] i_vel_y = '0;
    logic signed [VEL_W-1:0] i_yaw_rate = '0;
    logic                    i_cfg_we = 1'b0;
    logic [1:0]              i_cfg_index = '0;
    logic [RCP_W-1:0]        i_cfg_data = '0;
    logic                    o_strobe;
    logic [1:0]              o_wheel_index;
    logic signed [ANG_W-1:0] o_steer_angle;
    logic [SPD_W-1:0]        o_wheel_speed;
    logic                    o_last;

    wheel_scoreboard sb = new();

    swerve_inverse_kinematics u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_vel_x       (i_vel_x),
        .i_vel_y       (i_vel_y),
        .i_yaw_rate    (i_yaw_rate),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_wheel_index (o_wheel_index),
        .o_steer_angle (o_steer_angle),
        .o_wheel_speed (o_wheel_speed),
        .o_last        (o_last)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Watch register writes, accepted items and wheel results at each edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.set_register(i_cfg_index, i_cfg_data);
            if (start && !busy)
                sb.note_twist('{i_vel_x, i_vel_y, i_yaw_rate});
            if (o_strobe)
                sb.check_wheel('{o_wheel_index, o_steer_angle, o_wheel_speed, o_last});
        end
    end

    // -----------------------------------------------------------------------
    // Drivers
    // -----------------------------------------------------------------------
    // Present a twist and hold it until the block takes it; start stays high
    task automatic send_twist(input twist_t tw);
        start      <= 1'b1;
        i_vel_x    <= tw.vel_x;
        i_vel_y    <= tw.vel_y;
        i_yaw_rate <= tw.yaw_rate;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stop sending and wait until every pending wheel has come out
    task automatic drain_wheels();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_wheels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write geometry and radius back to back, optionally poke the unused index
    task automatic write_geometry(input logic [RCP_W-1:0] hb, input logic [RCP_W-1:0] ht,
                                  input logic [RCP_W-1:0] rr, input bit poke_unused);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_HALF_WHEEL_BASE;
        i_cfg_data  <= hb;
        @(posedge i_clk);
        i_cfg_index <= CFG_HALF_TRACK;
        i_cfg_data  <= ht;
        @(posedge i_clk);
        i_cfg_index <= CFG_RECIP_RADIUS;
        i_cfg_data  <= rr;
        @(posedge i_clk);
        if (poke_unused) begin
            i_cfg_index <= CFG_UNUSED;
            i_cfg_data  <= '1;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic twist_t make_twist(int vx, int vy, int w);
        twist_t tw;
        tw.vel_x    = vx[VEL_W-1:0];
        tw.vel_y    = vy[VEL_W-1:0];
        tw.yaw_rate = w[VEL_W-1:0];
        return tw;
    endfunction

    function automatic logic [VEL_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0001;
            default: return 16'h0000;
        endcase
    endfunction

    // Mix of full-range, small, extreme and single-motion twists
    function automatic twist_t random_twist();
        twist_t tw;
        tw.vel_x    = VEL_W'($urandom);
        tw.vel_y    = VEL_W'($urandom);
        tw.yaw_rate = VEL_W'($urandom);
        case ($urandom_range(0, 9))
            4, 5: begin
                tw = make_twist($urandom_range(0, 4000) - 2000,
                                $urandom_range(0, 4000) - 2000,
                                $urandom_range(0, 16384) - 8192);
            end
            6: begin
                tw.vel_x = pick_extreme();
                tw.vel_y = pick_extreme();
                tw.yaw_rate = pick_extreme();
            end
            7: begin
                tw.vel_x = '0;
                tw.vel_y = '0;
            end
            8: tw.yaw_rate = '0;
            9: begin
                if ($urandom_range(0, 1)) tw.vel_x = '0;
                else tw.vel_y = '0;
            end
            default: ;
        endcase
        return tw;
    endfunction

    task automatic run_random(input int count, input bit allow_idle);
        for (int i = 0; i < count; i++) begin
            send_twist(random_twist());
            if (allow_idle && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 9));
        end
    endtask

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial begin : stimulus
        twist_t directed[$];

        // Field extremes, axis directions, pure yaw and the zero cases
        directed.push_back(make_twist(0, 0, 0));
        directed.push_back(make_twist(32767, 0, 0));
        directed.push_back(make_twist(-32768, 0, 0));
        directed.push_back(make_twist(0, 32767, 0));
        directed.push_back(make_twist(0, -32768, 0));
        directed.push_back(make_twist(0, 0, 32767));
        directed.push_back(make_twist(0, 0, -32768));
        directed.push_back(make_twist(32767, 32767, 32767));
        directed.push_back(make_twist(-32768, -32768, -32768));
        directed.push_back(make_twist(-32768, 32767, -32768));
        directed.push_back(make_twist(1, 0, 0));
        directed.push_back(make_twist(-1, 0, 0));
        directed.push_back(make_twist(0, 1, 0));
        directed.push_back(make_twist(0, -1, 0));
        directed.push_back(make_twist(-1000, 0, 0));
        directed.push_back(make_twist(-1000, -1, 0));
        directed.push_back(make_twist(-1000, 1, 0));
        // Front-left wheel lands exactly on zero at default geometry in the first two
        directed.push_back(make_twist(150, -350, 4096));
        directed.push_back(make_twist(-150, 350, -4096));
        directed.push_back(make_twist(1200, -800, 2048));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed twists at reset geometry
        foreach (directed[i]) begin
            send_twist(directed[i]);
            if ($urandom_range(0, 2) == 0)
                pause_sender($urandom_range(1, 9));
        end
        drain_wheels();

        // Zero geometry, small radius reciprocal; drain once mid-phase
        write_geometry(21'd0, 21'd0, 21'd16777, 1'b0);
        run_random(PHASE_ITEMS / 2, 1'b1);
        drain_wheels();
        run_random(PHASE_ITEMS - PHASE_ITEMS / 2, 1'b1);
        drain_wheels();

        // Largest geometry, large radius reciprocal
        write_geometry(21'd4095, 21'd4095, 21'd1677722, 1'b0);
        run_random(PHASE_ITEMS, 1'b1);
        drain_wheels();

        // Upper data bits on the geometry writes, zero reciprocal, unused index
        write_geometry(RCP_W'(21'h1FF000 | $urandom_range(0, 4095)),
                       RCP_W'(21'h1FF000 | $urandom_range(0, 4095)), 21'd0, 1'b1);
        run_random(20, 1'b1);
        drain_wheels();

        // All-ones reciprocal
        write_geometry(RCP_W'($urandom_range(0, 4095)), RCP_W'($urandom_range(0, 4095)),
                       21'h1FFFFF, 1'b0);
        run_random(25, 1'b1);
        drain_wheels();

        // Back to default geometry, back-to-back twists
        write_geometry(21'd350, 21'd150, 21'd258111, 1'b0);
        run_random(PHASE_ITEMS, 1'b0);
        drain_wheels();

        if (sb.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard stop if the run hangs
    initial begin : watchdog
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
